[design/ahf_pkg.sv]
package ahf_pkg;

    localparam int NUM_BUCKETS = 256;
    localparam int WAYS        = 4;

    localparam int BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit BKT_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    // Bucket index by remainder: key bits per reduction step and step count
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = 64 / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [15:0] TIMEOUT_RST = 16'd120;

    localparam logic [1:0] ACT_FIND = 2'd0;
    localparam logic [1:0] ACT_ADD  = 2'd1;
    localparam logic [1:0] ACT_DEL  = 2'd2;

    typedef struct packed {
        logic [63:0]       key;
        logic [31:0]       value;
        logic [31:0]       stamp;
        logic [RANK_W-1:0] rank;
        logic              valid;
    } t_ahf_slot;

    typedef t_ahf_slot [WAYS-1:0] t_ahf_row;

    localparam int ROW_W = $bits(t_ahf_row);

    typedef struct packed {
        logic accept;
        logic clear;
        logic mod_step;
        logic eval;
        logic commit;
    } t_ahf_cmd;

    typedef struct packed {
        logic clr_last;
    } t_ahf_sts;

endpackage

[design/ahf_ram.sv]
module ahf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/ahf_ctrl.sv]
module ahf_ctrl
    import ahf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_ahf_sts i_sts,
    output t_ahf_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_EVAL,
        ST_WRITE
    } t_state;

    t_state               r_state, n_state;
    logic                 r_out_valid;
    logic [MOD_CNT_W-1:0] r_mod_cnt;

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear    = (r_state == ST_CLEAR);
        o_cmd.accept   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mod_step = (r_state == ST_MOD);
        o_cmd.eval     = (r_state == ST_EVAL);
        o_cmd.commit   = (r_state == ST_WRITE) && (!r_out_valid || i_out_ready);

        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (i_sts.clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = BKT_POW2 ? ST_READ : ST_MOD;
            ST_MOD:   if (r_mod_cnt == MOD_CNT_W'(MOD_STEPS - 1)) n_state = ST_READ;
            ST_READ:  n_state = ST_EVAL;
            ST_EVAL:  n_state = ST_WRITE;
            ST_WRITE: if (o_cmd.commit) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
            r_mod_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_cmd.mod_step) begin
                r_mod_cnt <= r_mod_cnt + 1'b1;
            end else begin
                r_mod_cnt <= '0;
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[design/ahf_dp.sv]
module ahf_dp
    import ahf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_key,
    input  logic [31:0] i_value,
    input  logic [31:0] i_now,
    input  t_ahf_cmd    i_cmd,
    output t_ahf_sts    o_sts,
    output logic        o_found,
    output logic [31:0] o_found_value,
    output logic        o_replaced
);

    logic [15:0]      r_timeout;
    logic [BKT_W-1:0] r_clr_addr;
    logic [1:0]       r_action;
    logic [63:0]      r_key;
    logic [63:0]      r_kshift;
    logic [31:0]      r_value;
    logic [31:0]      r_now;
    logic [BKT_W-1:0] r_bucket;
    t_ahf_row         r_row;
    logic [WAYS-1:0]  r_exp;
    logic [WAYS-1:0]  r_match;
    logic             r_found;
    logic [31:0]      r_found_value;
    logic             r_replaced;

    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] ram_wdata;
    logic [BKT_W-1:0] ram_waddr;
    logic             ram_we;
    t_ahf_row         rd_row;
    t_ahf_row         n_row;
    logic [BKT_W-1:0] n_rem;
    logic [WAYS-1:0]  n_exp;
    logic [WAYS-1:0]  n_match;
    logic             n_found;
    logic [31:0]      n_found_value;
    logic             n_replaced;

    ahf_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NUM_BUCKETS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_bucket),
        .o_rdata(ram_rdata)
    );

    assign rd_row          = t_ahf_row'(ram_rdata);
    assign o_sts.clr_last  = (r_clr_addr == BKT_W'(NUM_BUCKETS - 1));

    // Remainder by the bucket count, MOD_BITS key bits a cycle from the top
    always_comb begin
        logic [BKT_W:0] t;
        n_rem = r_bucket;
        for (int i = 0; i < MOD_BITS; i++) begin
            t = {n_rem, r_kshift[63 - i]};
            if (t >= (BKT_W + 1)'(NUM_BUCKETS)) begin
                t = t - (BKT_W + 1)'(NUM_BUCKETS);
            end
            n_rem = t[BKT_W-1:0];
        end
    end

    // Expiry test without wrap, and key compare
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            n_exp[w]   = rd_row[w].valid &&
                         (({1'b0, rd_row[w].stamp} + {17'b0, r_timeout}) < {1'b0, r_now});
            n_match[w] = rd_row[w].valid && (rd_row[w].key == r_key);
        end
    end

    // Row update: aging, hit handling, insert
    always_comb begin
        logic [WAYS-1:0]   surv;
        logic              hit;
        logic [RANK_W-1:0] hk;
        logic [RANK_W-1:0] rk;
        logic              full;
        logic              have_free;
        logic [RANK_W-1:0] tgt;
        surv          = '0;
        hit           = 1'b0;
        hk            = '0;
        have_free     = 1'b0;
        tgt           = '0;
        n_row         = r_row;
        n_found       = 1'b0;
        n_found_value = '0;
        n_replaced    = 1'b0;

        // an entry survives when a live entry of equal or greater age remains
        for (int w = 0; w < WAYS; w++) begin
            for (int u = 0; u < WAYS; u++) begin
                if (r_row[w].valid && r_row[u].valid && !r_exp[u] &&
                    r_row[u].rank >= r_row[w].rank) begin
                    surv[w] = 1'b1;
                end
            end
            n_row[w].valid = surv[w];
        end
        for (int w = 0; w < WAYS; w++) begin
            if (surv[w] && r_match[w] && !hit) begin
                hit = 1'b1;
                hk  = RANK_W'(w);
            end
        end
        rk   = r_row[hk].rank;
        full = &surv;
        for (int w = 0; w < WAYS; w++) begin
            if (!surv[w] && !have_free) begin
                have_free = 1'b1;
                tgt       = RANK_W'(w);
            end
        end
        if (full) begin
            for (int w = 0; w < WAYS; w++) begin
                if (r_row[w].rank == RANK_W'(WAYS - 1)) begin
                    tgt = RANK_W'(w);
                end
            end
        end

        if (r_action == ACT_FIND || r_action == ACT_ADD || r_action == ACT_DEL) begin
            if (hit) begin
                n_found = 1'b1;
                for (int w = 0; w < WAYS; w++) begin
                    if (surv[w] && RANK_W'(w) != hk) begin
                        if (r_action == ACT_DEL) begin
                            if (r_row[w].rank > rk) n_row[w].rank = r_row[w].rank - 1'b1;
                        end else begin
                            if (r_row[w].rank < rk) n_row[w].rank = r_row[w].rank + 1'b1;
                        end
                    end
                end
                n_row[hk].rank  = '0;
                n_row[hk].stamp = r_now;
                case (r_action)
                    ACT_FIND: n_found_value   = r_row[hk].value;
                    ACT_ADD:  n_row[hk].value = r_value;
                    default:  n_row[hk].valid = 1'b0;
                endcase
            end else if (r_action == ACT_ADD) begin
                n_replaced = full;
                for (int w = 0; w < WAYS; w++) begin
                    if (surv[w] && RANK_W'(w) != tgt) begin
                        n_row[w].rank = r_row[w].rank + 1'b1;
                    end
                end
                n_row[tgt].valid = 1'b1;
                n_row[tgt].key   = r_key;
                n_row[tgt].value = r_value;
                n_row[tgt].stamp = r_now;
                n_row[tgt].rank  = '0;
            end
        end
    end

    assign ram_we    = i_cmd.clear ||
                       (i_cmd.commit && (r_action == ACT_FIND || r_action == ACT_ADD ||
                                         r_action == ACT_DEL));
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_bucket;
    assign ram_wdata = i_cmd.clear ? '0 : ROW_W'(n_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RST;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_kshift <= i_key;
            r_value  <= i_value;
            r_now    <= i_now;
            r_bucket <= BKT_POW2 ? i_key[BKT_W-1:0] : '0;
        end
        if (i_cmd.mod_step) begin
            r_bucket <= n_rem;
            r_kshift <= r_kshift << MOD_BITS;
        end
        if (i_cmd.eval) begin
            r_row   <= rd_row;
            r_exp   <= n_exp;
            r_match <= n_match;
        end
        if (i_cmd.commit) begin
            r_found       <= n_found;
            r_found_value <= n_found_value;
            r_replaced    <= n_replaced;
        end
    end

    assign o_found       = r_found;
    assign o_found_value = r_found_value;
    assign o_replaced    = r_replaced;

endmodule

[design/aging_hash_flow_table.sv]
// Channel   | Direction | tdata                                  | tuser
// s_axis    | in        | key[63:0] value[95:64] now[127:96]     | action[1:0]
// m_axis    | out       | found_value[31:0]                      | found[0] replaced[1]
// cfg       | in        | i_cfg_wdata = timeout_seconds          | -
//
// Each word runs accept, bucket read, age/compare and write back with a
// power-of-two bucket count; otherwise key remainder steps, 4 bits a cycle, come before the read.
// Steps follow the registered RAM read and row write back; words do not overlap.
// After reset a clearing pass over all NUM_BUCKETS rows runs before the first word.
// A new word is taken while the last result waits; write back holds until it is taken.
module aging_hash_flow_table
    import ahf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // key, value, now_seconds
    input  logic [1:0]   s_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // found_value
    output logic [1:0]   m_axis_tuser    // found, replaced
);

    t_ahf_cmd cmd;
    t_ahf_sts sts;
    logic     found;
    logic     replaced;

    ahf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ahf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_action     (s_axis_tuser),
        .i_key        (s_axis_tdata[63:0]),
        .i_value      (s_axis_tdata[95:64]),
        .i_now        (s_axis_tdata[127:96]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_found      (found),
        .o_found_value(m_axis_tdata),
        .o_replaced   (replaced)
    );

    assign m_axis_tuser = {replaced, found};

endmodule

[verif/ahf_checker.sv]
`timescale 1ns / 1ps

module ahf_checker
    import ahf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    output int           o_fail_cnt,
    output int           o_pending,
    output int           o_results,
    output int           o_replaced,
    output int           o_hits
);

    typedef struct packed {
        logic        found;
        logic [31:0] found_value;
        logic        replaced;
    } t_lookup_res;

    logic [15:0] timeout_q;
    bit          tv [NUM_BUCKETS][WAYS];
    logic [63:0] tk [NUM_BUCKETS][WAYS];
    logic [31:0] tval [NUM_BUCKETS][WAYS];
    logic [31:0] tst [NUM_BUCKETS][WAYS];
    int          trk [NUM_BUCKETS][WAYS];
    t_lookup_res lookup_q[$];

    function automatic int oldest(int b);
        int best;
        best = -1;
        for (int w = 0; w < WAYS; w++)
            if (tv[b][w] && (best < 0 || trk[b][w] >= trk[b][best])) best = w;
        return best;
    endfunction

    function automatic void drop(int b, int s);
        tv[b][s] = 0;
        for (int w = 0; w < WAYS; w++)
            if (tv[b][w] && trk[b][w] > trk[b][s]) trk[b][w]--;
    endfunction

    function automatic t_lookup_res run_lookup(logic [1:0] act, logic [63:0] key,
                                               logic [31:0] val, logic [31:0] now);
        t_lookup_res r;
        int b, o, hit, fw;
        r = '0;
        if (act != ACT_FIND && act != ACT_ADD && act != ACT_DEL) return r;
        b = int'(key % NUM_BUCKETS);
        forever begin
            o = oldest(b);
            if (o < 0) break;
            if ({1'b0, tst[b][o]} + {17'd0, timeout_q} < {1'b0, now}) drop(b, o);
            else break;
        end
        hit = -1;
        for (int w = 0; w < WAYS; w++)
            if (hit < 0 && tv[b][w] && tk[b][w] == key) hit = w;
        if (hit >= 0) begin
            r.found = 1;
            tst[b][hit] = now;
            for (int w = 0; w < WAYS; w++)
                if (w != hit && tv[b][w] && trk[b][w] < trk[b][hit]) trk[b][w]++;
            trk[b][hit] = 0;
            if (act == ACT_FIND) r.found_value = tval[b][hit];
            else if (act == ACT_ADD) tval[b][hit] = val;
            else drop(b, hit);
        end else if (act == ACT_ADD) begin
            fw = -1;
            for (int w = 0; w < WAYS; w++)
                if (fw < 0 && !tv[b][w]) fw = w;
            if (fw < 0) begin
                fw = oldest(b);
                r.replaced = 1;
                drop(b, fw);
            end
            for (int w = 0; w < WAYS; w++)
                if (tv[b][w]) trk[b][w]++;
            tv[b][fw] = 1;
            tk[b][fw] = key;
            tval[b][fw] = val;
            tst[b][fw] = now;
            trk[b][fw] = 0;
        end
        return r;
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_cnt++;
    endtask

    assign o_pending = lookup_q.size();

    initial begin
        o_fail_cnt = 0;
        o_results = 0;
        o_replaced = 0;
        o_hits = 0;
        timeout_q = TIMEOUT_RST;
        for (int b = 0; b < NUM_BUCKETS; b++)
            for (int w = 0; w < WAYS; w++) tv[b][w] = 0;
    end

    always @(posedge i_clk) begin
        t_lookup_res e;
        if (i_rst_n) begin
            if (i_cfg_we) timeout_q = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                o_results++;
                if (lookup_q.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    e = lookup_q.pop_front();
                    if (m_axis_tuser[0] !== e.found)
                        report($sformatf("found %b, want %b", m_axis_tuser[0], e.found));
                    if (m_axis_tdata !== e.found_value)
                        report($sformatf("found_value %h, want %h", m_axis_tdata,
                                         e.found_value));
                    if (m_axis_tuser[1] !== e.replaced)
                        report($sformatf("replaced %b, want %b", m_axis_tuser[1],
                                         e.replaced));
                    if (e.replaced) o_replaced++;
                    if (e.found) o_hits++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                lookup_q.push_back(run_lookup(s_axis_tuser, s_axis_tdata[63:0],
                                              s_axis_tdata[95:64], s_axis_tdata[127:96]));
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ahf_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [15:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [31:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    int           fail_cnt, pending, results, replaced_cnt, hit_cnt;

    int  send_idle_pct = 25;
    int  recv_idle_pct = 25;
    bit  recv_hold = 0;
    int  words_sent = 0;

    logic [63:0] key_pool [16];
    logic [31:0] clock_s = 32'd1000;

    always #6 i_clk = ~i_clk;

    aging_hash_flow_table dut (.*);

    ahf_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_results(results),
        .o_replaced(replaced_cnt), .o_hits(hit_cnt)
    );

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (recv_hold) m_axis_tready <= 0;
        else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // tvalid stays up after an accepted word; it drops only for idle cycles or in drain
    task automatic send_word(logic [1:0] act, logic [63:0] key, logic [31:0] val,
                             logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {now, val, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [15:0] t);
        drain();
        i_cfg_we    <= 1;
        i_cfg_wdata <= t;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // mostly keys from a small pool that shares three buckets, time mostly creeping forward
    task automatic random_word;
        logic [63:0] key;
        logic [1:0]  act;
        int          p;
        p = $urandom_range(99);
        if (p < 80) key = key_pool[$urandom_range(15)];
        else key = {$urandom, $urandom};
        p = $urandom_range(99);
        act = (p < 35) ? ACT_FIND : (p < 75) ? ACT_ADD : (p < 95) ? ACT_DEL : ACT_UNUSED;
        p = $urandom_range(99);
        if (p < 85) clock_s = clock_s + $urandom_range(3);
        else if (p < 92) clock_s = clock_s + $urandom_range(200);
        else if (p < 96) clock_s = clock_s - $urandom_range(50);
        else clock_s = $urandom;
        send_word(act, key, $urandom, clock_s);
    endtask

    initial begin
        int hold;
        for (int i = 0; i < 16; i++)
            key_pool[i] = {$urandom, 24'd0, 8'(i % 3)} + (64'(i) << 8);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: default timeout, fill one bucket past its ways
        send_word(ACT_FIND, 64'h0, 32'h0, 32'h0);
        for (int i = 0; i < 5; i++)
            send_word(ACT_ADD, 64'(i) << 8, 32'hA0 + i, 32'd100 + i);
        send_word(ACT_FIND, 64'h100, 32'hFFFF_FFFF, 32'd110);
        send_word(ACT_ADD, 64'h200, 32'h1234_5678, 32'd110);
        send_word(ACT_DEL, 64'h300, 32'h0, 32'd111);
        send_word(ACT_DEL, 64'h300, 32'h0, 32'd111);
        send_word(ACT_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // time going backwards, then expiry of the whole bucket
        send_word(ACT_FIND, 64'h200, 32'h0, 32'd5);
        send_word(ACT_FIND, 64'h200, 32'h0, 32'd400);
        // stamps at the top of time never expire by overflow
        set_timeout(16'hFFFF);
        send_word(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_word(ACT_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        set_timeout(16'd0);
        send_word(ACT_ADD, 64'h5A, 32'h1, 32'd50);
        send_word(ACT_FIND, 64'h5A, 32'h0, 32'd50);
        send_word(ACT_FIND, 64'h5A, 32'h0, 32'd51);
        set_timeout(16'd20);

        // long hold-off on the result side while words keep coming
        fork
            begin
                recv_hold = 1;
                hold = 0;
                while (hold < 300) begin
                    @(posedge i_clk);
                    hold++;
                end
                recv_hold = 0;
            end
            for (int i = 0; i < 30; i++) random_word();
        join
        drain();

        // random phases through several timeouts; middle one without idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_timeout(16'd5);
                1: set_timeout(16'd60);
                2: begin
                    set_timeout(16'd0);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                3: begin
                    set_timeout(16'hFFFF);
                    send_idle_pct = 25;
                    recv_idle_pct = 25;
                end
                default: set_timeout(16'd120);
            endcase
            for (int i = 0; i < 200; i++) random_word();
        end
        drain();
        repeat (50) @(posedge i_clk);

        $display("covered %0d words, %0d results, %0d hits, %0d forced replacements",
                 words_sent, results, hit_cnt, replaced_cnt);
        $display("timeouts 0, 5, 20, 60, 120 and 65535 with time steps, jumps and rewinds");
        if (fail_cnt == 0 && pending == 0)
            $display("PASS aging_hash_flow_table");
        else
            $display("FAIL aging_hash_flow_table");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL aging_hash_flow_table");
        $finish;
    end

endmodule
